>>> hw/rtl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

>>> hw/rtl/vpfa_pkg.sv
package vpfa_pkg;

    // frame buffer and field limits
    localparam int unsigned MAX_FRAME_BYTES = 1048576;
    localparam int unsigned FILL_W          = 21;
    localparam int unsigned ADDR_W          = 20;
    localparam int unsigned PLEN_W          = 12;
    localparam int unsigned XFER_W          = 5;
    localparam int unsigned CFG_DATA_W      = 21;
    localparam int unsigned CFG_INDEX_W     = 1;

    localparam logic [FILL_W-1:0] FRAME_CAP_MAX   = FILL_W'(MAX_FRAME_BYTES);
    localparam logic [FILL_W-1:0] FRAME_CAP_RESET = FILL_W'(MAX_FRAME_BYTES);
    localparam logic [XFER_W-1:0] XFER_RESET      = 5'd2;
    localparam logic [XFER_W-1:0] XFER_COUNT_MAX  = 5'd31;
    localparam logic [PLEN_W-1:0] BYTE_INDEX_MAX  = 12'd4095;
    localparam logic [PLEN_W-1:0] MIN_HEADER      = 12'd2;

    // header flag bits
    localparam int unsigned FLAG_ERROR_BIT = 6;
    localparam int unsigned FLAG_EOF_BIT   = 1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_CAPACITY      = 1'b0,
        REG_TRANSFERS_PER_FRAME = 1'b1
    } cfg_reg_t;

    // input item kinds
    localparam logic KIND_PACKET_BYTE = 1'b0;

    typedef struct packed {
        logic              kind;
        logic [7:0]        data_byte;
        logic              packet_first;
        logic              packet_last;
        logic [PLEN_W-1:0] packet_length;
        logic              packet_failed;
        logic              transfer_failed;
    } in_item_t;

    typedef struct packed {
        logic              store_valid;
        logic [ADDR_W-1:0] store_address;
        logic [7:0]        store_byte;
        logic              frame_ready;
        logic [FILL_W-1:0] frame_length;
        logic              resubmit;
    } out_item_t;

endpackage

>>> hw/rtl/video_payload_frame_assembler_top.sv
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    in_data   (packet byte or end of transfer)
// out      output     out_valid/out_ready  out_data  (store, frame ready, resubmit)
// cfg      input      cfg_we               cfg_index, cfg_data
//
// one transaction per cycle sustained while the output is not stalled; each item passes
// from acceptance through the input register and then the result register.
// the frame state updates when an item moves from the input register to the result
// register, through one 21-bit compare and increment of the fill level.
// reset clears all frame state and loads the default configuration.
// a stalled output holds its result; the input register keeps one more item.
module video_payload_frame_assembler_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  vpfa_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output vpfa_pkg::out_item_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [vpfa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [vpfa_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import vpfa_pkg::*;

    // handshake and pipeline registers
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      advance;
    logic      stage_fire;

    // configuration
    logic [FILL_W-1:0] capacity_reg;
    logic [XFER_W-1:0] transfers_reg;

    // frame state
    logic [FILL_W-1:0] fill_level_reg,     fill_level_next;
    logic              frame_done_reg,     frame_done_next;
    logic [XFER_W-1:0] done_transfers_reg, done_transfers_next;
    logic [7:0]        header_length_reg,  header_length_next;
    logic [PLEN_W-1:0] byte_index_reg,     byte_index_next;
    logic              packet_skip_reg,    packet_skip_next;
    logic              eof_flag_reg,       eof_flag_next;

    logic [FILL_W-1:0] eff_capacity;
    logic [XFER_W-1:0] done_inc;
    logic [PLEN_W-1:0] index_base;

    // result register moves when empty or taken; input register when it can drain
    assign advance    = !out_valid_reg || out_ready;
    assign in_ready   = !in_valid_reg || advance;
    assign stage_fire = in_valid_reg && advance;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_item_reg;

    assign eff_capacity = (capacity_reg > FRAME_CAP_MAX) ? FRAME_CAP_MAX : capacity_reg;

    // per-item frame logic
    always_comb
    begin
        fill_level_next     = fill_level_reg;
        frame_done_next     = frame_done_reg;
        done_transfers_next = done_transfers_reg;
        header_length_next  = header_length_reg;
        byte_index_next     = byte_index_reg;
        packet_skip_next    = packet_skip_reg;
        eof_flag_next       = eof_flag_reg;
        out_item_next       = '0;
        done_inc            = (done_transfers_reg < XFER_COUNT_MAX) ?
                              done_transfers_reg + 5'd1 : done_transfers_reg;
        index_base          = in_item_reg.packet_first ? '0 : byte_index_reg;

        if (in_item_reg.kind != KIND_PACKET_BYTE)
        begin
            // end of transfer marker
            packet_skip_next = 1'b1;
            byte_index_next  = '0;
            if (!in_item_reg.transfer_failed)
            begin
                if (!frame_done_reg)
                begin
                    out_item_next.resubmit = 1'b1;
                end
                else
                begin
                    frame_done_next     = 1'b0;
                    done_transfers_next = done_inc;
                    if (done_inc >= transfers_reg)
                    begin
                        out_item_next.frame_ready  = 1'b1;
                        out_item_next.frame_length = fill_level_reg;
                        fill_level_next            = '0;
                        done_transfers_next        = '0;
                    end
                end
            end
        end
        else
        begin
            if (in_item_reg.packet_first)
            begin
                // header length byte opens a packet
                header_length_next = in_item_reg.data_byte;
                eof_flag_next      = 1'b0;
                packet_skip_next   = in_item_reg.packet_failed || in_item_reg.transfer_failed
                                     || frame_done_reg
                                     || (in_item_reg.packet_length < MIN_HEADER)
                                     || ({4'd0, in_item_reg.data_byte} < MIN_HEADER)
                                     || ({4'd0, in_item_reg.data_byte}
                                         > in_item_reg.packet_length);
            end
            else if (!packet_skip_reg && (byte_index_reg < in_item_reg.packet_length))
            begin
                if (byte_index_reg == 12'd1)
                begin
                    // flags byte
                    if (in_item_reg.data_byte[FLAG_ERROR_BIT])
                        packet_skip_next = 1'b1;
                    else
                        eof_flag_next = in_item_reg.data_byte[FLAG_EOF_BIT];
                end
                else if (byte_index_reg >= {4'd0, header_length_reg})
                begin
                    // payload byte, stored while it fits
                    if (fill_level_reg < eff_capacity)
                    begin
                        out_item_next.store_valid   = 1'b1;
                        out_item_next.store_address = fill_level_reg[ADDR_W-1:0];
                        out_item_next.store_byte    = in_item_reg.data_byte;
                        fill_level_next             = fill_level_reg + 21'd1;
                    end
                    else
                    begin
                        frame_done_next = 1'b1;
                    end
                end
            end

            // end of packet closes it and checks end of frame
            if (in_item_reg.packet_last)
            begin
                if (!packet_skip_next && eof_flag_next && (fill_level_next != '0))
                    frame_done_next = 1'b1;
                packet_skip_next = 1'b1;
            end

            byte_index_next = (index_base < BYTE_INDEX_MAX) ? index_base + 12'd1 : index_base;
        end
    end

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_data;
        if (stage_fire)
            out_item_reg <= out_item_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= FRAME_CAP_RESET;
            transfers_reg <= XFER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_CAPACITY:      capacity_reg  <= cfg_data;
                REG_TRANSFERS_PER_FRAME: transfers_reg <= cfg_data[XFER_W-1:0];
                default:                 ;
            endcase
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_level_reg     <= '0;
            frame_done_reg     <= 1'b0;
            done_transfers_reg <= '0;
            header_length_reg  <= '0;
            byte_index_reg     <= '0;
            packet_skip_reg    <= 1'b0;
            eof_flag_reg       <= 1'b0;
        end
        else if (stage_fire)
        begin
            fill_level_reg     <= fill_level_next;
            frame_done_reg     <= frame_done_next;
            done_transfers_reg <= done_transfers_next;
            header_length_reg  <= header_length_next;
            byte_index_reg     <= byte_index_next;
            packet_skip_reg    <= packet_skip_next;
            eof_flag_reg       <= eof_flag_next;
        end
    end

endmodule

>>> hw/rtl/vpfa_checker.sv
module vpfa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input vpfa_pkg::out_item_t out_data
);
    import vpfa_pkg::*;
    `include "assert_macros.svh"

    // a stalled result holds
    `ASSERT_PROP(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
    // a store comes from a packet byte, frame ready and resubmit from a marker
    `ASSERT_NEVER(a_store_excl,
                  out_valid && out_data.store_valid
                  && (out_data.frame_ready || out_data.resubmit))
    // a marker either resubmits or completes a frame, never both
    `ASSERT_NEVER(a_marker_excl, out_valid && out_data.frame_ready && out_data.resubmit)
    // idle fields of a result are zero
    `ASSERT_PROP(a_zero_fields,
                 out_valid && !out_data.frame_ready && !out_data.store_valid
                 |-> out_data.frame_length == '0 && out_data.store_address == '0)

endmodule

bind video_payload_frame_assembler_top vpfa_checker u_vpfa_checker (.*);
